@@ design/ctg_pkg.sv @@
// shared types and constants for the conditional text gate
package ctg_pkg;

  localparam int NEST_DEPTH_DEF = 16;

  localparam int CMD_W   = 3;
  localparam int DATA_W  = 64;
  localparam int FAULT_W = 3;
  localparam int LEVEL_W = 5;
  localparam int ENTRY_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TOKEN  = 3'd0,
    CMD_IFDEF  = 3'd1,
    CMD_IFNDEF = 3'd2,
    CMD_ELSIF  = 3'd3,
    CMD_ELSE   = 3'd4,
    CMD_ENDIF  = 3'd5,
    CMD_EOI    = 3'd6
  } cmd_t;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE         = 3'd0,
    FAULT_STRAY_ELSIF  = 3'd1,
    FAULT_STRAY_ELSE   = 3'd2,
    FAULT_STRAY_ENDIF  = 3'd3,
    FAULT_UNTERMINATED = 3'd4,
    FAULT_OVERFLOW     = 3'd5
  } fault_t;

  // stack entry: bit 0 on, bit 1 ever on
  localparam int BIT_ON   = 0;
  localparam int BIT_EVER = 1;

endpackage

@@ design/conditional_text_gate.sv @@
// conditional text gate: token stream gated by nested ifdef/elsif/else/endif
//
//  channel  | ports                                         | dir
//  ---------+-----------------------------------------------+-----
//  in       | in_valid in_stall in_command in_symbol_defined | in
//           | in_token_data                                  |
//  out      | out_valid out_stall out_emit out_data_out      | out
//           | out_fault out_level out_active                 |
//
// one request per cycle while not stalled, one registered result per request.
// the top level sits in a register; the levels under it sit in a ram read at
// (open levels - 2) every cycle, so a pop finds the new top ready in the next
// cycle, with a bypass when a push writes the entry being read.
// rst_n (synchronous) empties the stack; the ram itself is not cleared.
// in_stall follows out_stall only while the result register is full.
module conditional_text_gate #(
  parameter int NEST_DEPTH = ctg_pkg::NEST_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ctg_pkg::CMD_W-1:0]     in_command,
  input  logic                          in_symbol_defined,
  input  logic [ctg_pkg::DATA_W-1:0]    in_token_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_emit,
  output logic [ctg_pkg::DATA_W-1:0]    out_data_out,
  output logic [ctg_pkg::FAULT_W-1:0]   out_fault,
  output logic [ctg_pkg::LEVEL_W-1:0]   out_level,
  output logic                          out_active
);

  localparam int CNT_W = $clog2(NEST_DEPTH + 1);
  localparam int AW    = NEST_DEPTH > 1 ? $clog2(NEST_DEPTH) : 1;
  localparam int EW    = ctg_pkg::ENTRY_W;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] off_r, off_nxt;
  logic [EW-1:0]    top_r, top_nxt;
  logic             byp_r, byp_nxt;
  logic [EW-1:0]    byp_data_r;

  logic             out_valid_r;
  logic             emit_r, emit_nxt;
  logic [ctg_pkg::DATA_W-1:0]  data_r;
  logic [ctg_pkg::FAULT_W-1:0] fault_r;
  ctg_pkg::fault_t  fault_nxt;

  logic             accept;
  logic             wr_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [EW-1:0]    ram_rd;
  logic [EW-1:0]    below;
  logic             enable;
  logic [CNT_W-1:0] off_tmp;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // entry under the top, from the ram or from a write it has not seen yet
  assign below = byp_r ? byp_data_r : ram_rd;

  always_comb begin
    count_nxt = count_r;
    off_nxt   = off_r;
    top_nxt   = top_r;
    emit_nxt  = 1'b0;
    fault_nxt = ctg_pkg::FAULT_NONE;
    wr_en     = 1'b0;
    enable    = 1'b0;
    off_tmp   = off_r;
    if (accept) begin
      case (in_command)
        ctg_pkg::CMD_TOKEN: begin
          emit_nxt = (off_r == '0);
        end
        ctg_pkg::CMD_IFDEF, ctg_pkg::CMD_IFNDEF: begin
          enable = (in_command == ctg_pkg::CMD_IFNDEF) ? ~in_symbol_defined
                                                       : in_symbol_defined;
          if (count_r >= CNT_W'(NEST_DEPTH)) begin
            fault_nxt = ctg_pkg::FAULT_OVERFLOW;
          end else begin
            wr_en     = (count_r != '0);
            top_nxt   = {enable, enable};
            count_nxt = count_r + CNT_W'(1);
            if (!enable) begin
              off_nxt = off_r + CNT_W'(1);
            end
          end
        end
        ctg_pkg::CMD_ELSIF, ctg_pkg::CMD_ELSE: begin
          if (count_r == '0) begin
            fault_nxt = (in_command == ctg_pkg::CMD_ELSIF) ? ctg_pkg::FAULT_STRAY_ELSIF
                                                           : ctg_pkg::FAULT_STRAY_ELSE;
          end else begin
            enable = ~top_r[ctg_pkg::BIT_EVER] &
                     ((in_command == ctg_pkg::CMD_ELSE) | in_symbol_defined);
            if (!top_r[ctg_pkg::BIT_ON] && off_r != '0) begin
              off_tmp = off_r - CNT_W'(1);
            end
            off_nxt = enable ? off_tmp : off_tmp + CNT_W'(1);
            top_nxt = {top_r[ctg_pkg::BIT_EVER] | enable, enable};
          end
        end
        ctg_pkg::CMD_ENDIF: begin
          if (count_r == '0) begin
            fault_nxt = ctg_pkg::FAULT_STRAY_ENDIF;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            top_nxt   = below;
            if (!top_r[ctg_pkg::BIT_ON] && off_r != '0) begin
              off_nxt = off_r - CNT_W'(1);
            end
          end
        end
        ctg_pkg::CMD_EOI: begin
          if (count_r != '0) begin
            fault_nxt = ctg_pkg::FAULT_UNTERMINATED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // the old top moves into the ram on a push
  assign wr_addr = AW'(count_r - CNT_W'(1));
  assign rd_addr = AW'(count_nxt - CNT_W'(2));
  assign byp_nxt = wr_en & (wr_addr == rd_addr);

  ctg_ram #(
    .WIDTH (EW),
    .DEPTH (NEST_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (top_r),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      off_r       <= '0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      off_r   <= off_nxt;
      byp_r   <= byp_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    byp_data_r <= top_r;
    if (accept) begin
      emit_r  <= emit_nxt;
      data_r  <= in_token_data;
      fault_r <= fault_nxt;
    end
  end

  logic [ctg_pkg::LEVEL_W-1:0] level_r;
  logic                        active_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      level_r  <= ctg_pkg::LEVEL_W'(count_nxt);
      active_r <= (off_nxt == '0);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_emit     = emit_r;
  assign out_data_out = data_r;
  assign out_fault    = fault_r;
  assign out_level    = level_r;
  assign out_active   = active_r;

endmodule

@@ design/ctg_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module ctg_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
